// ===== hw/rtl/gvc_pkg.sv =====
// ----------------------------------------------------------------------------
// gvc_pkg
// Shared widths, stream layouts and controller/datapath interface types for
// the greedy vertex color assigner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gvc_pkg;

  // fixed field widths
  localparam int ID_W      = 10;
  localparam int COLOR_W   = 6;

  // stream payload widths
  localparam int S_TDATA_W = 24;
  localparam int S_TUSER_W = 1;
  localparam int M_TDATA_W = 16;
  localparam int M_TUSER_W = 2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic clr_wr;   // write one zero entry of the clearing pass
    logic accept;   // capture a request, read the neighbor color
    logic nbr_upd;  // neighbor color is back, update the forbidden mask
    logic vtx_rd;   // read the stored color of the vertex
    logic vtx_cap;  // vertex color is back, capture it with the pick
    logic finish;   // load the result, write the store, reset the mask
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic clr_done; // clearing pass writes its last entry this cycle
    logic last;     // captured request closes the run
    logic out_free; // output register can take a result this cycle
  } sts_t;

endpackage

// ===== hw/rtl/gvc_ram.sv =====
// ----------------------------------------------------------------------------
// gvc_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gvc_ram #(
  parameter  int WIDTH  = 6,
  parameter  int DEPTH  = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hw/rtl/gvc_ctrl.sv =====
// ----------------------------------------------------------------------------
// gvc_ctrl
// Controller: clearing pass, per-request read sequence and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gvc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  gvc_pkg::sts_t sts,
  output gvc_pkg::cmd_t cmd
);

  import gvc_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_NBR   = 5'b00100,
    S_VTX   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tready && s_axis_tvalid;

  // command decode
  always_comb begin
    cmd         = '0;
    cmd.clr_wr  = (state == S_CLEAR);
    cmd.accept  = accept;
    cmd.nbr_upd = (state == S_NBR);
    cmd.vtx_rd  = (state == S_NBR) && sts.last;
    cmd.vtx_cap = (state == S_VTX);
    cmd.finish  = (state == S_DONE) && sts.out_free;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (sts.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_next = S_NBR;
      end
      S_NBR: begin
        state_next = sts.last ? S_VTX : S_IDLE;
      end
      S_VTX: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/gvc_datapath.sv =====
// ----------------------------------------------------------------------------
// gvc_datapath
// Color store, forbidden mask, first-free search and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gvc_datapath #(
  parameter int NODE_COUNT = 1024,
  parameter int MAX_DEGREE = 62
) (
  input  logic                               clk,
  input  logic                               rst,
  input  gvc_pkg::cmd_t                      cmd,
  output gvc_pkg::sts_t                      sts,
  input  logic [gvc_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  input  logic [gvc_pkg::S_TUSER_W-1:0]      s_axis_tuser,
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [gvc_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  output logic [gvc_pkg::M_TUSER_W-1:0]      m_axis_tuser
);

  import gvc_pkg::*;

  // ids are 10 bits wide, so no more than 1024 entries are ever addressed
  localparam int MEM_DEPTH = (NODE_COUNT < (1 << ID_W)) ? NODE_COUNT : (1 << ID_W);
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int SLOTS     = MAX_DEGREE + 2;
  localparam int TOP_COLOR = MAX_DEGREE + 1;
  localparam int NGRP      = (SLOTS + 7) / 8;
  localparam int GRP_W     = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int PAD_W     = NGRP * 8;

  logic [ID_W-1:0]    in_vertex;
  logic [ID_W-1:0]    in_neighbor;

  logic [ID_W-1:0]    vtx_q;
  logic               vtx_ok_q;
  logic               nbr_ok_q;
  logic               nvalid_q;
  logic               last_q;
  logic [COLOR_W-1:0] stored_q;
  logic [COLOR_W-1:0] pick_q;
  logic               over_q;

  logic [SLOTS-1:0]   mask;
  logic [ADDR_W-1:0]  clr_cnt;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  logic [COLOR_W-1:0] ram_wdata;
  logic [COLOR_W-1:0] ram_rdata;

  logic [PAD_W-1:0]   free_pad;
  logic [NGRP-1:0]    grp_any;
  logic [GRP_W-1:0]   grp_sel;
  logic [7:0]         grp_bits;
  logic [2:0]         bit_sel;
  logic [COLOR_W-1:0] pick;
  logic               over;

  logic               out_valid;
  logic [ID_W-1:0]    out_vertex;
  logic [COLOR_W-1:0] out_color;
  logic               out_already;
  logic               out_over;

  assign in_vertex   = s_axis_tdata[ID_W-1:0];
  assign in_neighbor = s_axis_tdata[2*ID_W-1:ID_W];

  // color store access
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = in_neighbor[ADDR_W-1:0];
    ram_wdata = pick_q;
    if (cmd.clr_wr) begin
      ram_we    = 1'b1;
      ram_addr  = clr_cnt;
      ram_wdata = '0;
    end else if (cmd.vtx_rd) begin
      ram_addr  = vtx_q[ADDR_W-1:0];
    end else if (cmd.finish) begin
      ram_we    = (stored_q == '0) && vtx_ok_q;
      ram_addr  = vtx_q[ADDR_W-1:0];
    end
  end

  gvc_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (rst) begin
      last_q <= 1'b0;
    end else if (cmd.accept) begin
      vtx_q    <= in_vertex;
      vtx_ok_q <= 32'(in_vertex) < NODE_COUNT;
      nbr_ok_q <= 32'(in_neighbor) < NODE_COUNT;
      nvalid_q <= s_axis_tuser[0];
      last_q   <= s_axis_tlast;
    end
  end

  // forbidden mask, bit zero always set
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      mask <= SLOTS'(1);
    end else if (cmd.nbr_upd && nvalid_q && nbr_ok_q) begin
      for (int i = 1; i < SLOTS; i++) begin
        if (ram_rdata == COLOR_W'(i)) mask[i] <= 1'b1;
      end
    end
  end

  // first free color: pick the lowest group of eight, then the bit in it
  always_comb begin
    free_pad             = '0;
    free_pad[SLOTS-1:0]  = ~mask;
    for (int g = 0; g < NGRP; g++) begin
      grp_any[g] = |free_pad[g*8 +: 8];
    end
    grp_sel = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any[g]) grp_sel = GRP_W'(g);
    end
    grp_bits = free_pad[{grp_sel, 3'b000} +: 8];
    bit_sel  = '0;
    for (int b = 7; b >= 0; b--) begin
      if (grp_bits[b]) bit_sel = 3'(b);
    end
    over = ~|grp_any;
    pick = over ? COLOR_W'(TOP_COLOR) : COLOR_W'({grp_sel, bit_sel});
  end

  // vertex color and pick capture
  always_ff @(posedge clk) begin
    if (cmd.vtx_cap) begin
      stored_q <= vtx_ok_q ? ram_rdata : '0;
      pick_q   <= pick;
      over_q   <= over;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_vertex  <= vtx_q;
      out_already <= (stored_q != '0);
      out_color   <= (stored_q != '0) ? stored_q : pick_q;
      out_over    <= (stored_q == '0) && over_q;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_color, out_vertex};
  assign m_axis_tuser  = {out_over, out_already};

  // status
  always_comb begin
    sts          = '0;
    sts.clr_done = cmd.clr_wr && (clr_cnt == ADDR_W'(MEM_DEPTH - 1));
    sts.last     = last_q;
    sts.out_free = !out_valid || m_axis_tready;
  end

endmodule

// ===== hw/rtl/greedy_vertex_color_assign.sv =====
// Sequence: a request without last is accepted, then its neighbor color returns from the store.
// A last request goes on through the neighbor read, the vertex read and the first-free
// pick to a result in the output register, and waits while that register is still full.
// The single port of the color store is shared, so no new request is taken until the
// store read of the last one has returned, nor until a last request loads its result.
// Reset: synchronous; a clearing pass zeroes all min(NODE_COUNT, 1024) store entries.
// ----------------------------------------------------------------------------
// greedy_vertex_color_assign
// First-fit greedy vertex coloring over a stream of neighbor requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module greedy_vertex_color_assign #(
  parameter int NODE_COUNT = 1024,
  parameter int MAX_DEGREE = 62
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [9:0] vertex, [19:10] neighbor, [23:20] zero
  input  logic [gvc_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // [0] neighbor_valid
  input  logic [gvc_pkg::S_TUSER_W-1:0] s_axis_tuser,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [9:0] colored_vertex, [15:10] color
  output logic [gvc_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // [0] already_colored, [1] overflow
  output logic [gvc_pkg::M_TUSER_W-1:0] m_axis_tuser
);

  import gvc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // controller
  gvc_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts           (sts),
    .cmd           (cmd)
  );

  // datapath
  gvc_datapath #(
    .NODE_COUNT (NODE_COUNT),
    .MAX_DEGREE (MAX_DEGREE)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

`ifndef SYNTHESIS
  // no request is taken during the clearing pass
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_wr |-> !s_axis_tready)
    else $error("request ready during clearing pass");

  // every request waits for its store read
  a_one_per_two: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted before store read returned");

  // a finished result shows up on the output
  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> m_axis_tvalid)
    else $error("result lost after finish");

  // overflow saturates at the top color
  a_over_top: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[1]) |->
      (m_axis_tdata[15:10] == 6'(MAX_DEGREE + 1)) && !m_axis_tuser[0])
    else $error("overflow without saturated color");
`endif

endmodule

// ===== dv/tb_greedy_vertex_color_assign.sv =====
// ----------------------------------------------------------------------------
// tb_greedy_vertex_color_assign
// Self-checking bench for the first-fit vertex colorer. A short table of
// directed requests covers isolated vertices, recolor lookups, self and
// duplicate neighbors, invalid neighbors and a vertex change inside a run.
// Random runs follow: one thread grows a chain of vertices whose colors climb
// to the top color and then force saturation, mixed with short random runs.
// Every result is compared field by field against the color store model or a typed row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_greedy_vertex_color_assign;
  import gvc_pkg::*;

  localparam int NODE_COUNT   = 1024;
  localparam int MAX_DEGREE   = 62;
  localparam int TOP_COLOR    = MAX_DEGREE + 1;
  localparam int COLOR_SLOTS  = MAX_DEGREE + 2;
  localparam int ITEM_TARGET  = 1750;
  localparam int PHASE1_END   = 700;
  localparam int PHASE2_END   = 1400;
  localparam int HOLD_CYCLES  = 400;
  // clearing pass after reset writes all 1024 store entries, so stay well clear of it
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 16;
  localparam int DIRECTED_N   = 19;
  localparam int EXTRA_TOP    = 16;

  typedef struct packed {
    logic [ID_W-1:0]    vtx;
    logic [COLOR_W-1:0] color;
    logic               already;
    logic               over;
  } color_result_t;

  typedef struct packed {
    logic [ID_W-1:0]    vtx;
    logic [ID_W-1:0]    nbr;
    logic               nv;
    logic               lst;
    logic               typed;
    logic [COLOR_W-1:0] color;
    logic               already;
    logic               over;
  } stim_row_t;

  // vtx, nbr, nv, lst, typed, color, already, over
  localparam stim_row_t DIRECTED [DIRECTED_N] = '{
    '{10'd0,    10'd0,    1'b0, 1'b1, 1'b1, 6'd1, 1'b0, 1'b0}, // isolated vertex
    '{10'd1023, 10'd0,    1'b1, 1'b1, 1'b1, 6'd2, 1'b0, 1'b0},
    '{10'd0,    10'd1023, 1'b1, 1'b1, 1'b1, 6'd1, 1'b1, 1'b0}, // already colored
    '{10'd11,   10'd11,   1'b1, 1'b1, 1'b1, 6'd1, 1'b0, 1'b0}, // self, mask was cleared
    '{10'd5,    10'd0,    1'b1, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0},
    '{10'd5,    10'd1023, 1'b1, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0},
    '{10'd5,    10'd5,    1'b1, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0},
    '{10'd5,    10'd7,    1'b1, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0},
    '{10'd5,    10'd1023, 1'b0, 1'b1, 1'b0, 6'd0, 1'b0, 1'b0}, // invalid closing request
    '{10'd100,  10'd0,    1'b1, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0}, // vertex changes mid run
    '{10'd200,  10'd5,    1'b1, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0},
    '{10'd300,  10'd1023, 1'b1, 1'b1, 1'b0, 6'd0, 1'b0, 1'b0},
    '{10'd9,    10'd0,    1'b0, 1'b1, 1'b1, 6'd1, 1'b0, 1'b0}, // invalid neighbor ignored
    '{10'd10,   10'd0,    1'b1, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0}, // duplicate neighbor
    '{10'd10,   10'd0,    1'b1, 1'b1, 1'b0, 6'd0, 1'b0, 1'b0},
    '{10'd682,  10'd341,  1'b1, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0},
    '{10'd341,  10'd682,  1'b1, 1'b1, 1'b0, 6'd0, 1'b0, 1'b0},
    '{10'd1023, 10'd300,  1'b1, 1'b1, 1'b1, 6'd2, 1'b1, 1'b0},
    '{10'd300,  10'd0,    1'b1, 1'b1, 1'b1, 6'd4, 1'b1, 1'b0}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [S_TUSER_W-1:0] s_axis_tuser = '0;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [M_TUSER_W-1:0] m_axis_tuser;

  // behavioral color store and forbidden mask
  logic [COLOR_W-1:0]     node_color [NODE_COUNT];
  logic [COLOR_SLOTS-1:0] banned_colors;
  color_result_t          pending_colors [$];

  int  tx_idle_pct = 37;
  int  rx_idle_pct = 85;
  bit  hold_go = 1'b0;
  int  hold_left = HOLD_CYCLES;
  int  items_sent = 0;
  int  runs_done = 0;
  int  overflow_runs = 0;
  int  results_checked = 0;
  int  already_seen = 0;
  int  mismatches = 0;
  int  stall_cycles = 0;

  greedy_vertex_color_assign #(
    .NODE_COUNT(NODE_COUNT),
    .MAX_DEGREE(MAX_DEGREE)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // first-fit pick: fold one request into the mask, emit on the closing one
  function automatic bit greedy_pick(input logic [ID_W-1:0] vtx, input logic [ID_W-1:0] nbr,
                                     input logic nv, input logic lst,
                                     output color_result_t res);
    logic [COLOR_W-1:0] c;
    bit found;
    res = '0;
    if (nv) begin
      c = node_color[nbr];
      if (c != '0) banned_colors[c] = 1'b1;
    end
    if (!lst) return 1'b0;
    res.vtx = vtx;
    if (node_color[vtx] != '0) begin
      res.color   = node_color[vtx];
      res.already = 1'b1;
    end else begin
      found = 1'b0;
      res.color = COLOR_W'(TOP_COLOR);
      for (int i = 1; i < COLOR_SLOTS; i++) begin
        if (!found && !banned_colors[i]) begin
          res.color = COLOR_W'(i);
          found = 1'b1;
        end
      end
      res.over = !found;
      node_color[vtx] = res.color;
    end
    banned_colors = COLOR_SLOTS'(1);
    return 1'b1;
  endfunction

  function automatic int highest_color();
    int top;
    top = 0;
    for (int i = 0; i < NODE_COUNT; i++)
      if (int'(node_color[i]) > top) top = int'(node_color[i]);
    return top;
  endfunction

  // some node holding color c, scanned from a random start
  function automatic logic [ID_W-1:0] node_of_color(input int c);
    int start;
    start = $urandom_range(0, NODE_COUNT - 1);
    for (int k = 0; k < NODE_COUNT; k++)
      if (int'(node_color[(start + k) % NODE_COUNT]) == c)
        return ID_W'((start + k) % NODE_COUNT);
    return ID_W'(start);
  endfunction

  function automatic logic [ID_W-1:0] uncolored_node();
    int start;
    start = $urandom_range(0, NODE_COUNT - 1);
    for (int k = 0; k < NODE_COUNT; k++)
      if (node_color[(start + k) % NODE_COUNT] == '0)
        return ID_W'((start + k) % NODE_COUNT);
    return ID_W'(start);
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("mismatch on %s: expected %0d, got %0d (result %0d)",
             what, want, got, results_checked);
    mismatches++;
  endtask

  // offer one request, wait for its handshake, then predict
  task automatic send_item(input logic [ID_W-1:0] vtx, input logic [ID_W-1:0] nbr,
                           input logic nv, input logic lst,
                           input bit typed = 1'b0, input color_result_t typed_res = '0);
    color_result_t res;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(S_TDATA_W - 2 * ID_W){1'b0}}, nbr, vtx};
    s_axis_tuser  <= nv;
    s_axis_tlast  <= lst;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    if (greedy_pick(vtx, nbr, nv, lst, res)) begin
      if (typed) res = typed_res;
      pending_colors.insert(pending_colors.size(), res);
      runs_done++;
      if (res.over) overflow_runs++;
    end
  endtask

  // one vertex whose neighbors hold every color so far: climbs by one each time
  task automatic chain_step();
    logic [ID_W-1:0] nbrs [$];
    logic [ID_W-1:0] vtx;
    logic [ID_W-1:0] tmp;
    int top;
    int j;
    bit close_invalid;
    bit stray;
    top = highest_color();
    vtx = uncolored_node();
    for (int c = 1; c <= top; c++) nbrs.insert(nbrs.size(), node_of_color(c));
    for (int i = nbrs.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = nbrs[i];
      nbrs[i] = nbrs[j];
      nbrs[j] = tmp;
    end
    close_invalid = (nbrs.size() == 0) || ($urandom_range(0, 3) == 0);
    foreach (nbrs[i]) begin
      // extra invalid and repeated requests only while the chain is short
      if (top < EXTRA_TOP && $urandom_range(0, 9) == 0)
        send_item(ID_W'($urandom), ID_W'($urandom), 1'b0, 1'b0);
      if (top < EXTRA_TOP && $urandom_range(0, 11) == 0 && i > 0)
        send_item(vtx, nbrs[$urandom_range(0, i - 1)], 1'b1, 1'b0);
      stray = (i != nbrs.size() - 1 || close_invalid) && ($urandom_range(0, 15) == 0);
      send_item(stray ? ID_W'($urandom) : vtx, nbrs[i], 1'b1,
                (i == nbrs.size() - 1) && !close_invalid);
    end
    if (close_invalid) send_item(vtx, ID_W'($urandom), 1'b0, 1'b1);
  endtask

  // short run with random neighbors, often ones that carry a color
  task automatic random_run();
    logic [ID_W-1:0] vtx;
    logic [ID_W-1:0] nbr;
    int len;
    int top;
    top = highest_color();
    len = $urandom_range(1, 6);
    vtx = $urandom_range(0, 1) ? uncolored_node() : ID_W'($urandom);
    for (int i = 0; i < len; i++) begin
      if (top > 0 && $urandom_range(0, 1)) nbr = node_of_color($urandom_range(1, top));
      else nbr = ID_W'($urandom);
      send_item((i == len - 1 || $urandom_range(0, 7) != 0) ? vtx : ID_W'($urandom),
                nbr, $urandom_range(0, 7) != 0, i == len - 1);
    end
  endtask

  // result side: random back-pressure, one long hold, field checks
  always @(posedge clk) begin : result_side
    color_result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_colors.size() == 0) begin
          report_mismatch("unexpected result, vertex", -1, int'(m_axis_tdata[ID_W-1:0]));
        end else begin
          want = pending_colors.pop_front();
          if (m_axis_tdata[ID_W-1:0] !== want.vtx)
            report_mismatch("colored_vertex", int'(want.vtx),
                            int'(m_axis_tdata[ID_W-1:0]));
          if (m_axis_tdata[ID_W+COLOR_W-1:ID_W] !== want.color)
            report_mismatch("color", int'(want.color),
                            int'(m_axis_tdata[ID_W+COLOR_W-1:ID_W]));
          if (m_axis_tuser[0] !== want.already)
            report_mismatch("already_colored", int'(want.already), int'(m_axis_tuser[0]));
          if (m_axis_tuser[1] !== want.over)
            report_mismatch("overflow", int'(want.over), int'(m_axis_tuser[1]));
          if (want.already) already_seen++;
        end
        results_checked++;
      end
      if (hold_go && hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left <= hold_left - 1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles, %0d results pending",
                 STALL_LIMIT, pending_colors.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    color_result_t row_res;
    for (int i = 0; i < NODE_COUNT; i++) node_color[i] = '0;
    banned_colors = COLOR_SLOTS'(1);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int r = 0; r < DIRECTED_N; r++) begin
      row_res = '{vtx: DIRECTED[r].vtx, color: DIRECTED[r].color,
                  already: DIRECTED[r].already, over: DIRECTED[r].over};
      send_item(DIRECTED[r].vtx, DIRECTED[r].nbr, DIRECTED[r].nv, DIRECTED[r].lst,
                DIRECTED[r].typed, row_res);
    end

    // random runs: color chain up to saturation, mixed with short runs
    hold_go <= 1'b1;
    while (overflow_runs < 1 || items_sent < ITEM_TARGET) begin
      if (items_sent < PHASE1_END) begin
        tx_idle_pct = 37;
        rx_idle_pct <= 85;
      end else if (items_sent < PHASE2_END) begin
        tx_idle_pct = 85;
        rx_idle_pct <= 37;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      if (overflow_runs < 1 && $urandom_range(0, 7) != 0) chain_step();
      else random_run();
    end
    s_axis_tvalid <= 1'b0;

    while (pending_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests in %0d vertex runs, %0d results checked",
             items_sent, runs_done, results_checked);
    $display("highest color %0d, %0d saturated runs, %0d recolor lookups",
             highest_color(), overflow_runs, already_seen);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
